FILE: src/sida_pkg.sv
package sida_pkg;

    // Field widths of the item channels
    localparam int ACTION_W    = 4;
    localparam int STREAM_ID_W = 8;
    localparam int GRANT_W     = 8;
    localparam int FLAG_W      = 5;

    // Per-ID membership flags
    localparam logic [FLAG_W-1:0] FLAG_REG    = 5'b00001;
    localparam logic [FLAG_W-1:0] FLAG_OPEN   = 5'b00010;
    localparam logic [FLAG_W-1:0] FLAG_LISTEN = 5'b00100;
    localparam logic [FLAG_W-1:0] FLAG_RSV    = 5'b01000;
    localparam logic [FLAG_W-1:0] FLAG_RET    = 5'b10000;

    // Action codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOCATE     = 4'd0,
        ACT_RESERVE_PEER = 4'd1,
        ACT_REG_COMPLETE = 4'd2,
        ACT_REGISTER     = 4'd3,
        ACT_UNREGISTER   = 4'd4,
        ACT_RETIRE       = 4'd5,
        ACT_RELEASE      = 4'd6,
        ACT_PEND_OPEN    = 4'd7,
        ACT_PEND_LISTEN  = 4'd8,
        ACT_SHUTDOWN     = 4'd9
    } t_action;

    typedef struct packed {
        logic [ACTION_W-1:0]    action;
        logic [STREAM_ID_W-1:0] strm_id;
    } t_in_item;

    typedef struct packed {
        logic               ok;
        logic [GRANT_W-1:0] granted_id;
        logic               stop_flag;
    } t_out_item;

    // Controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_SCAN,
        ST_WIPE,
        ST_DONE
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic clr_step;
        logic scan_init;
        logic scan_step;
        logic upd;
        logic shut;
        logic push;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_alloc;
        logic is_shut;
        logic stopped;
        logic clr_last;
        logic scan_hit;
        logic scan_end;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: src/sida_ctrl.sv
module sida_ctrl
    import sida_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register; reset starts the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_READ;
                end
            end
            ST_READ: begin
                if (i_stat.is_alloc && !i_stat.stopped) begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = ST_SCAN;
                end else if (i_stat.is_shut && !i_stat.stopped) begin
                    o_cmd.shut = 1'b1;
                    n_state    = ST_WIPE;
                end else begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                o_cmd.upd = 1'b1;
                n_state   = ST_DONE;
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_hit || i_stat.scan_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_WIPE: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/sida_dpath.sv
module sida_dpath
    import sida_pkg::*;
#(
    parameter int ID_WIDTH = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_data,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int DEPTH = 1 << ID_WIDTH;
    localparam logic [ID_WIDTH-1:0] SCAN_LIMIT = {ID_WIDTH{1'b1}};

    // Flag memory and its registered read data
    logic [FLAG_W-1:0]   r_mem [DEPTH];
    logic [FLAG_W-1:0]   r_rd_flags;

    t_in_item            r_item;
    t_out_item           r_res;
    t_out_item           r_out_data;
    logic                r_out_valid;
    logic                r_stopped;
    logic [ID_WIDTH-1:0] r_next_id;
    logic [ID_WIDTH-1:0] r_clr_addr;
    logic [ID_WIDTH-1:0] r_iss_cnt;
    logic                r_chk_vld;
    logic [ID_WIDTH-1:0] r_chk_cand;

    logic [ID_WIDTH-1:0] id;
    logic                id_zero;
    logic [ID_WIDTH-1:0] cand;
    logic [ID_WIDTH-1:0] ptr_adv;
    logic                hit;
    logic                issue;
    logic                scan_end;
    logic                out_free;
    logic [ID_WIDTH-1:0] mem_raddr;
    logic                mem_we;
    logic [ID_WIDTH-1:0] mem_waddr;
    logic [FLAG_W-1:0]   mem_wdata;
    logic                upd_we;
    logic                upd_ok;
    logic [FLAG_W-1:0]   upd_flags;
    logic [FLAG_W-1:0]   pend;

    assign id      = ID_WIDTH'(r_item.strm_id);
    assign id_zero = (id == '0);

    // Next-fit candidate: skip ID 0 by taking the following one
    assign cand    = (r_next_id == '0) ? ID_WIDTH'(1) : r_next_id;
    assign ptr_adv = (r_next_id == '0) ? r_next_id + ID_WIDTH'(2)
                                       : r_next_id + ID_WIDTH'(1);

    // Scan: check the candidate read last cycle, issue the next one
    assign hit      = r_chk_vld && (r_rd_flags == '0);
    assign issue    = i_cmd.scan_step && (r_iss_cnt != SCAN_LIMIT) && !hit;
    assign scan_end = !r_chk_vld && (r_iss_cnt == SCAN_LIMIT);
    assign out_free = !r_out_valid || !i_out_stall;

    assign mem_raddr = issue ? cand : id;

    // Flag update for single-ID actions
    always_comb begin
        upd_we    = 1'b0;
        upd_ok    = 1'b0;
        upd_flags = r_rd_flags;
        pend      = (r_item.action == ACT_PEND_OPEN) ? FLAG_OPEN : FLAG_LISTEN;
        case (r_item.action)
            ACT_RESERVE_PEER: begin
                if (!id_zero && !r_stopped && r_rd_flags == '0) begin
                    upd_flags = r_rd_flags | FLAG_RSV;
                    upd_we    = 1'b1;
                    upd_ok    = 1'b1;
                end
            end
            ACT_REG_COMPLETE: begin
                upd_ok    = |(r_rd_flags & FLAG_REG);
                upd_flags = r_rd_flags & ~FLAG_RSV;
                upd_we    = 1'b1;
            end
            ACT_REGISTER: begin
                if (!r_stopped && !id_zero &&
                    (r_rd_flags & (FLAG_REG | FLAG_OPEN | FLAG_LISTEN | FLAG_RET)) == '0)
                begin
                    upd_flags = (r_rd_flags | FLAG_REG) & ~FLAG_RSV;
                    upd_we    = 1'b1;
                    upd_ok    = 1'b1;
                end
            end
            ACT_UNREGISTER: begin
                upd_flags = r_rd_flags & ~(FLAG_RSV | FLAG_REG | FLAG_OPEN | FLAG_LISTEN);
                upd_we    = 1'b1;
                upd_ok    = 1'b1;
            end
            ACT_RETIRE: begin
                if (!id_zero) begin
                    upd_flags = FLAG_RET;
                    upd_we    = 1'b1;
                    upd_ok    = 1'b1;
                end
            end
            ACT_RELEASE: begin
                upd_flags = r_rd_flags & ~FLAG_RSV;
                upd_we    = 1'b1;
                upd_ok    = 1'b1;
            end
            ACT_PEND_OPEN, ACT_PEND_LISTEN: begin
                upd_we = 1'b1;
                if (r_stopped) begin
                    upd_flags = r_rd_flags & ~FLAG_RSV & ~pend;
                end else begin
                    upd_flags = (r_rd_flags & ~FLAG_RSV) | pend;
                    upd_ok    = 1'b1;
                end
            end
            default: begin
                // allocate or shutdown while stopped, and unknown codes: no change
                upd_we = 1'b0;
            end
        endcase
    end

    // Select the single write port
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = id;
        mem_wdata = upd_flags;
        if (i_cmd.clr_step) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else if (i_cmd.scan_step && hit) begin
            mem_we    = 1'b1;
            mem_waddr = r_chk_cand;
            mem_wdata = FLAG_RSV;
        end else if (i_cmd.upd) begin
            mem_we = upd_we;
        end
    end

    // Flag memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_flags <= r_mem[mem_raddr];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stopped   <= 1'b0;
            r_next_id   <= ID_WIDTH'(1);
            r_clr_addr  <= '0;
            r_iss_cnt   <= '0;
            r_chk_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + ID_WIDTH'(1);
            end
            if (i_cmd.shut) begin
                r_stopped <= 1'b1;
            end
            if (i_cmd.scan_init) begin
                r_iss_cnt <= '0;
                r_chk_vld <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_chk_vld <= issue;
                if (hit) begin
                    r_next_id <= r_chk_cand + ID_WIDTH'(1);
                end else if (issue) begin
                    r_next_id <= ptr_adv;
                    r_iss_cnt <= r_iss_cnt + ID_WIDTH'(1);
                end
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: latched item, pending result, output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_data;
        end
        if (issue) begin
            r_chk_cand <= cand;
        end
        if (i_cmd.upd) begin
            r_res.ok         <= upd_ok;
            r_res.granted_id <= '0;
            r_res.stop_flag  <= r_stopped;
        end else if (i_cmd.shut) begin
            r_res.ok         <= 1'b1;
            r_res.granted_id <= '0;
            r_res.stop_flag  <= 1'b1;
        end else if (i_cmd.scan_step && hit) begin
            r_res.ok         <= 1'b1;
            r_res.granted_id <= GRANT_W'(r_chk_cand);
            r_res.stop_flag  <= r_stopped;
        end else if (i_cmd.scan_step && scan_end) begin
            r_res.ok         <= 1'b0;
            r_res.granted_id <= '0;
            r_res.stop_flag  <= r_stopped;
        end
        if (i_cmd.push) begin
            r_out_data <= r_res;
        end
    end

    assign o_stat.is_alloc = (r_item.action == ACT_ALLOCATE);
    assign o_stat.is_shut  = (r_item.action == ACT_SHUTDOWN);
    assign o_stat.stopped  = r_stopped;
    assign o_stat.clr_last = (r_clr_addr == SCAN_LIMIT);
    assign o_stat.scan_hit = hit;
    assign o_stat.scan_end = scan_end;
    assign o_stat.out_free = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: src/stream_id_allocator_core.sv
// Stream ID allocator: membership flags for 2^ID_WIDTH stream IDs, a
// next-fit allocation pointer and a stopped flag.
// Input channel (i_in_valid / o_in_stall / i_in_data) takes one action item;
// output channel (o_out_valid / i_out_stall / o_out_data) returns one result
// item per action, in order.
// The block works on one item at a time, paced by the flag memory, which has
// one write port and one registered read port. Single-ID actions step through
// the read, update and done states. Allocate examines 1 to 2^ID_WIDTH - 1
// candidates, one memory read per cycle. Shutdown (when running) clears every
// entry. After reset the flag memory is cleared one entry per cycle with
// o_in_stall high; the pointer starts at 1 and stopped is low.
// A result sits in an output register; when the receiver stalls it holds,
// the next item is still accepted, and its result waits until the register
// frees up.
module stream_id_allocator_core
    import sida_pkg::*;
#(
    parameter int ID_WIDTH = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequence each action
    sida_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Hold flags, pointer and results
    sida_dpath #(
        .ID_WIDTH (ID_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: src/sida_chk.sv
module sida_chk
    import sida_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    logic r_seen_stop;

    // Track whether a stopped result has been delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_stop <= 1'b0;
        end else if (o_out_valid && !i_out_stall && o_out_data.stop_flag) begin
            r_seen_stop <= 1'b1;
        end
    end

    // One item at a time: an accepted item stalls the input next cycle
    a_in_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted on back-to-back cycles");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // Stopped never clears without reset
    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_seen_stop |-> o_out_data.stop_flag)
        else $error("stopped flag dropped");

    // No grant while stopped
    a_no_grant_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.stop_flag |-> o_out_data.granted_id == '0)
        else $error("ID granted while stopped");

    // A grant always reports success
    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.granted_id != '0 |-> o_out_data.ok)
        else $error("grant without ok");

endmodule

bind stream_id_allocator_core sida_chk u_sida_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

FILE: bench/tb.sv
`timescale 1ns / 100ps

module tb;
    import sida_pkg::*;

    localparam int ID_W         = 8;
    localparam int N_IDS        = 1 << ID_W;
    localparam int SCAN_SPAN    = N_IDS - 1;
    localparam int ACT_CODE_MAX = (1 << ACTION_W) - 1;
    localparam int HOT_POOL     = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AT_A    = 2000;
    localparam int HOLD_AT_B    = 12000;
    localparam int SETTLE_CYCLES = 2 * N_IDS + 16;
    localparam int MAX_PRINTED  = 200;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    // Predicted block state
    logic [FLAG_W-1:0] id_state [0:N_IDS-1];
    logic [ID_W-1:0]   alloc_ptr;
    logic              halted;

    t_in_item    pending_items [$];
    t_out_item   expected_results [$];
    t_out_item   want;

    int unsigned n_sent = 0;
    int unsigned n_checked = 0;
    int unsigned n_granted = 0;
    int unsigned n_halted_seen = 0;
    int unsigned n_errors = 0;
    int unsigned tx_gap = 0;
    int unsigned rx_wait = 0;
    int unsigned cyc_cnt = 0;
    int unsigned hold_left = 0;
    logic        rx_hold = 1'b0;
    logic        tx_took;
    logic        tx_drain = 1'b0;
    logic        tx_calm = 1'b0;
    logic        rx_calm = 1'b0;

    stream_id_allocator_core #(
        .ID_WIDTH(ID_W)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Hold reset from time zero, then release it, once
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Apply one action to the predicted state and return its result
    function automatic t_out_item apply_action(t_in_item it);
        t_out_item         res;
        logic [ID_W-1:0]   sid;
        logic [ID_W-1:0]   cand;
        logic [FLAG_W-1:0] pend;
        logic              found;
        int                n;
        res = '0;
        sid = it.strm_id[ID_W-1:0];
        case (it.action)
            ACT_ALLOCATE: begin
                found = 1'b0;
                if (!halted) begin
                    for (n = 0; n < SCAN_SPAN && !found; n++) begin
                        cand = alloc_ptr;
                        alloc_ptr = alloc_ptr + 1'b1;
                        // ID zero is never a candidate: take the following one
                        if (cand == '0) begin
                            cand = alloc_ptr;
                            alloc_ptr = alloc_ptr + 1'b1;
                        end
                        if (id_state[cand] == '0) begin
                            id_state[cand] = FLAG_RSV;
                            res.granted_id = cand;
                            res.ok = 1'b1;
                            found = 1'b1;
                        end
                    end
                end
            end
            ACT_RESERVE_PEER: begin
                if (sid != '0 && !halted && id_state[sid] == '0) begin
                    id_state[sid] = FLAG_RSV;
                    res.ok = 1'b1;
                end
            end
            ACT_REG_COMPLETE: begin
                res.ok = (id_state[sid] & FLAG_REG) != '0;
                id_state[sid] = id_state[sid] & ~FLAG_RSV;
            end
            ACT_REGISTER: begin
                if (!halted && sid != '0 &&
                    (id_state[sid] & (FLAG_REG | FLAG_OPEN | FLAG_LISTEN | FLAG_RET))
                        == '0) begin
                    id_state[sid] = (id_state[sid] | FLAG_REG) & ~FLAG_RSV;
                    res.ok = 1'b1;
                end
            end
            ACT_UNREGISTER: begin
                id_state[sid] = id_state[sid] &
                                ~(FLAG_RSV | FLAG_REG | FLAG_OPEN | FLAG_LISTEN);
                res.ok = 1'b1;
            end
            ACT_RETIRE: begin
                if (sid != '0) begin
                    id_state[sid] = FLAG_RET;
                    res.ok = 1'b1;
                end
            end
            ACT_RELEASE: begin
                id_state[sid] = id_state[sid] & ~FLAG_RSV;
                res.ok = 1'b1;
            end
            ACT_PEND_OPEN, ACT_PEND_LISTEN: begin
                pend = (it.action == ACT_PEND_OPEN) ? FLAG_OPEN : FLAG_LISTEN;
                id_state[sid] = id_state[sid] & ~FLAG_RSV;
                if (halted) begin
                    id_state[sid] = id_state[sid] & ~pend;
                end else begin
                    id_state[sid] = id_state[sid] | pend;
                    res.ok = 1'b1;
                end
            end
            ACT_SHUTDOWN: begin
                if (!halted) begin
                    halted = 1'b1;
                    for (n = 0; n < N_IDS; n++) id_state[n] = '0;
                    res.ok = 1'b1;
                end
            end
            default: begin
                // unknown codes change nothing
            end
        endcase
        res.stop_flag = halted;
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        if (n_errors < MAX_PRINTED) $display("MISMATCH: %s", msg);
        n_errors++;
    endtask

    task automatic add(logic [ACTION_W-1:0] act, logic [STREAM_ID_W-1:0] sid);
        t_in_item it;
        it.action = act;
        it.strm_id = sid;
        pending_items = {pending_items, it};
    endtask

    // Mostly a small hot set so that actions on one ID interact
    function automatic logic [STREAM_ID_W-1:0] pick_id();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return STREAM_ID_W'($urandom_range(1, HOT_POOL));
        if (r < 80) return STREAM_ID_W'($urandom_range(N_IDS - 6, N_IDS - 1));
        if (r < 85) return '0;
        return STREAM_ID_W'($urandom_range(0, N_IDS - 1));
    endfunction

    // Random item of any code but shutdown
    task automatic add_noise();
        logic [ACTION_W-1:0] act;
        act = ACTION_W'($urandom_range(0, ACT_CODE_MAX));
        if (act == ACT_SHUTDOWN) act = ACT_REG_COMPLETE;
        add(act, STREAM_ID_W'($urandom_range(0, N_IDS - 1)));
    endtask

    // Stream lifecycles with random IDs, dropped steps and noise between them
    task automatic add_lifecycles(int unsigned count);
        t_action                plan [5];
        logic [STREAM_ID_W-1:0] sid;
        int unsigned            added;
        added = 0;
        while (added < count) begin
            sid = pick_id();
            case ($urandom_range(0, 4))
                0: plan = '{ACT_ALLOCATE, ACT_RESERVE_PEER, ACT_REGISTER,
                            ACT_REG_COMPLETE, ACT_RELEASE};
                1: plan = '{ACT_RESERVE_PEER, ACT_REGISTER, ACT_REG_COMPLETE,
                            ACT_PEND_OPEN, ACT_UNREGISTER};
                2: begin
                    // retire sticks, so keep it off the hot set
                    sid = STREAM_ID_W'($urandom_range(0, N_IDS - 1));
                    plan = '{ACT_REGISTER, ACT_PEND_LISTEN, ACT_RETIRE,
                             ACT_REGISTER, ACT_RELEASE};
                end
                3: plan = '{ACT_PEND_OPEN, ACT_REGISTER, ACT_UNREGISTER,
                            ACT_REGISTER, ACT_REG_COMPLETE};
                default: plan = '{ACT_RESERVE_PEER, ACT_PEND_LISTEN, ACT_REG_COMPLETE,
                                  ACT_UNREGISTER, ACT_ALLOCATE};
            endcase
            foreach (plan[k]) begin
                if ($urandom_range(0, 99) >= 12) begin
                    add(plan[k], sid);
                    added++;
                end
                if ($urandom_range(0, 99) < 15) begin
                    add_noise();
                    added++;
                end
            end
        end
    endtask

    // Driver: offer pending items, hold a stalled item, draw a gap per item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            tx_took = in_valid && !in_stall;
            if (tx_took) begin
                expected_results = {expected_results, apply_action(in_data)};
                n_sent++;
                if (n_sent % 100 == 0) tx_calm = ($urandom_range(0, 3) == 0);
                tx_gap = tx_calm ? 0 : $urandom_range(0, 8);
                if (n_sent % 500 == 250) tx_drain = 1'b1;
            end
            if (!in_valid || tx_took) begin
                if (tx_drain && expected_results.size() != 0) begin
                    in_valid <= 1'b0;
                end else if (tx_gap != 0) begin
                    tx_gap--;
                    in_valid <= 1'b0;
                end else if (pending_items.size() == 0) begin
                    in_valid <= 1'b0;
                end else begin
                    tx_drain = 1'b0;
                    in_valid <= 1'b1;
                    in_data <= pending_items[0];
                    pending_items.delete(0);
                end
            end
        end
    end

    // Long hold-off of the receiver so that the block backs up into its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cyc_cnt = 0;
            hold_left = 0;
            rx_hold <= 1'b0;
        end else begin
            cyc_cnt++;
            if (cyc_cnt == HOLD_AT_A || cyc_cnt == HOLD_AT_B) begin
                hold_left = HOLD_CYCLES;
            end else if (hold_left != 0) begin
                hold_left--;
            end
            rx_hold <= (hold_left != 0);
        end
    end

    // Monitor: check each accepted result, draw a stall per result
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            rx_wait = 0;
        end else begin
            if (out_valid && !out_stall) begin
                n_checked++;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              n_checked));
                end else begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    if (out_data.ok !== want.ok)
                        report_mismatch($sformatf("result %0d ok: got %b, want %b",
                                                  n_checked, out_data.ok, want.ok));
                    if (out_data.granted_id !== want.granted_id)
                        report_mismatch($sformatf("result %0d granted_id: got %0d, want %0d",
                                                  n_checked, out_data.granted_id,
                                                  want.granted_id));
                    if (out_data.stop_flag !== want.stop_flag)
                        report_mismatch($sformatf("result %0d stopped: got %b, want %b",
                                                  n_checked, out_data.stop_flag,
                                                  want.stop_flag));
                end
                if (out_data.granted_id != '0) n_granted++;
                if (out_data.stop_flag) n_halted_seen++;
                if (n_checked % 100 == 0) rx_calm = ($urandom_range(0, 3) == 0);
                rx_wait = rx_calm ? 0 : $urandom_range(0, 8);
            end else if (rx_wait != 0) begin
                rx_wait--;
            end
            out_stall <= (rx_wait != 0) || rx_hold;
        end
    end

    // Stimulus and end of run
    initial begin
        for (int n = 0; n < N_IDS; n++) id_state[n] = '0;
        alloc_ptr = ID_W'(1);
        halted = 1'b0;

        // Directed: extremes, every action but shutdown, ID zero and unknown codes
        add(ACT_ALLOCATE, '0);
        add(ACT_ALLOCATE, '1);
        add(ACT_RESERVE_PEER, '0);
        add(ACT_RESERVE_PEER, '1);
        add(ACT_RESERVE_PEER, '1);
        add(ACT_REGISTER, '1);
        add(ACT_REGISTER, '1);
        add(ACT_REG_COMPLETE, '1);
        add(ACT_REG_COMPLETE, 8'd3);
        add(ACT_REGISTER, '0);
        add(ACT_UNREGISTER, '1);
        add(ACT_RETIRE, '0);
        add(ACT_RETIRE, 8'd2);
        add(ACT_REGISTER, 8'd2);
        add(ACT_RELEASE, 8'd1);
        add(ACT_PEND_OPEN, '0);
        add(ACT_PEND_LISTEN, '0);
        add(ACT_ALLOCATE, '0);
        add(ACT_UNREGISTER, '0);
        add(ACT_RELEASE, '0);
        add(ACT_REG_COMPLETE, '0);
        add(ACTION_W'(ACT_CODE_MAX), 8'hAA);
        add(ACTION_W'(ACT_SHUTDOWN + 1), 8'h55);
        add(ACT_PEND_OPEN, 8'h80);

        // Lifecycles on a mostly small ID set
        add_lifecycles(600);

        // Fill every ID, run the scan dry across the wrap, then free and reuse
        repeat (SCAN_SPAN + 3) add(ACT_ALLOCATE, STREAM_ID_W'($urandom_range(0, N_IDS - 1)));
        repeat (20) begin
            add($urandom_range(0, 1) ? ACT_RELEASE : ACT_UNREGISTER,
                STREAM_ID_W'($urandom_range(0, N_IDS - 1)));
            add(ACT_ALLOCATE, '0);
        end

        // Mixed lifecycles and noise over the full ID range
        add_lifecycles(250);
        repeat (250) add_noise();

        // Stop the block, then every action while stopped
        add(ACT_SHUTDOWN, STREAM_ID_W'($urandom_range(0, N_IDS - 1)));
        add(ACT_SHUTDOWN, STREAM_ID_W'($urandom_range(0, N_IDS - 1)));
        for (int a = 0; a <= ACT_SHUTDOWN; a++) add(ACTION_W'(a), pick_id());
        repeat (140) add(ACTION_W'($urandom_range(0, ACT_CODE_MAX)),
                         STREAM_ID_W'($urandom_range(0, N_IDS - 1)));

        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("run: %0d items sent, %0d results checked, %0d IDs granted, %0d while stopped",
                 n_sent, n_checked, n_granted, n_halted_seen);
        $display("run: all actions, ID zero, allocation exhaustion and pointer wrap, long stalls");
        if (n_errors == 0) begin
            $display("stream_id_allocator_core regression: pass");
        end else begin
            $display("stream_id_allocator_core regression: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20ms;
        $display("stream_id_allocator_core regression: fail");
        $finish;
    end

endmodule
